### rtl/utf8v_pkg.sv
package utf8v_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_mark;
    } in_item_t;

    typedef struct packed {
        logic text_invalid;
        logic final_verdict;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  bytes_pending;
        logic [2:0]  sequence_length;
        logic [20:0] code_accumulator;
        logic        error_seen;
    } dec_state_t;

    localparam logic [7:0]  LEAD2_LO    = 8'hC2;
    localparam logic [7:0]  LEAD2_HI    = 8'hDF;
    localparam logic [7:0]  LEAD3_LO    = 8'hE0;
    localparam logic [7:0]  LEAD3_HI    = 8'hEF;
    localparam logic [7:0]  LEAD4_LO    = 8'hF0;
    localparam logic [7:0]  LEAD4_HI    = 8'hF4;
    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_TAG    = 8'h80;

    localparam logic [2:0]  LEN_TWO     = 3'd2;
    localparam logic [2:0]  LEN_THREE   = 3'd3;
    localparam logic [2:0]  LEN_FOUR    = 3'd4;

    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] MIN_FOUR    = 21'h010000;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] CODE_MAX    = 21'h10FFFF;

endpackage

### rtl/utf8v_step.sv
module utf8v_step (
    input  utf8v_pkg::dec_state_t state_cur,
    input  utf8v_pkg::in_item_t   item,
    output utf8v_pkg::dec_state_t state_nxt,
    output utf8v_pkg::out_item_t  result
);

    logic [7:0]  b;
    logic [20:0] cp;
    logic        is_cont;
    logic        overlong;
    logic        out_of_range;

    assign b       = item.data_byte;
    assign cp      = {state_cur.code_accumulator[14:0], b[5:0]};
    assign is_cont = ((b & utf8v_pkg::CONT_MASK) == utf8v_pkg::CONT_TAG);

    assign overlong =
        ((state_cur.sequence_length == utf8v_pkg::LEN_TWO)   && (cp < utf8v_pkg::MIN_TWO))   ||
        ((state_cur.sequence_length == utf8v_pkg::LEN_THREE) && (cp < utf8v_pkg::MIN_THREE)) ||
        ((state_cur.sequence_length == utf8v_pkg::LEN_FOUR)  && (cp < utf8v_pkg::MIN_FOUR));

    assign out_of_range = ((cp >= utf8v_pkg::SURR_LO) && (cp <= utf8v_pkg::SURR_HI)) ||
                          (cp > utf8v_pkg::CODE_MAX);

    always_comb begin
        state_nxt = state_cur;
        priority if (item.end_mark) begin
            // end of text: cut-short sequence counts as an error, then clear
            state_nxt = '0;
        end else if (state_cur.error_seen) begin
            // hold: decode is frozen after an error
        end else if (state_cur.bytes_pending == 2'd0) begin
            priority if (b == 8'h00) begin
                state_nxt.error_seen = 1'b1;
            end else if (b < utf8v_pkg::ASCII_LIMIT) begin
                // single-byte character
            end else if ((b >= utf8v_pkg::LEAD2_LO) && (b <= utf8v_pkg::LEAD2_HI)) begin
                state_nxt.bytes_pending    = 2'd1;
                state_nxt.sequence_length  = utf8v_pkg::LEN_TWO;
                state_nxt.code_accumulator = {16'd0, b[4:0]};
            end else if ((b >= utf8v_pkg::LEAD3_LO) && (b <= utf8v_pkg::LEAD3_HI)) begin
                state_nxt.bytes_pending    = 2'd2;
                state_nxt.sequence_length  = utf8v_pkg::LEN_THREE;
                state_nxt.code_accumulator = {17'd0, b[3:0]};
            end else if ((b >= utf8v_pkg::LEAD4_LO) && (b <= utf8v_pkg::LEAD4_HI)) begin
                state_nxt.bytes_pending    = 2'd3;
                state_nxt.sequence_length  = utf8v_pkg::LEN_FOUR;
                state_nxt.code_accumulator = {18'd0, b[2:0]};
            end else begin
                state_nxt.error_seen = 1'b1;
            end
        end else if (!is_cont) begin
            state_nxt.error_seen = 1'b1;
        end else if (state_cur.bytes_pending != 2'd1) begin
            state_nxt.bytes_pending    = state_cur.bytes_pending - 2'd1;
            state_nxt.code_accumulator = cp;
        end else begin
            // last continuation: check the finished codepoint
            state_nxt.bytes_pending    = 2'd0;
            state_nxt.sequence_length  = 3'd0;
            state_nxt.code_accumulator = '0;
            state_nxt.error_seen       = overlong || out_of_range;
        end
    end

    always_comb begin
        if (item.end_mark) begin
            result.text_invalid  = state_cur.error_seen || (state_cur.bytes_pending != 2'd0);
            result.final_verdict = 1'b1;
        end else begin
            result.text_invalid  = state_nxt.error_seen;
            result.final_verdict = 1'b0;
        end
    end

endmodule

### rtl/utf8_stream_validator_unit.sv
// Each accepted byte is captured in the input register; its verdict is registered in the
// result register, which drives m_data.
// Throughput: one item per cycle unless m_ready stalls; both registers advance together.
// Reset: aresetn low at a rising edge empties both stages and clears the decode state.
// The decode state also clears after every end-of-text item.
module utf8_stream_validator_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utf8v_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output utf8v_pkg::out_item_t m_data
);

    logic                  in_valid_reg;
    utf8v_pkg::in_item_t   in_reg;
    logic                  out_valid_reg;
    utf8v_pkg::out_item_t  out_reg;
    utf8v_pkg::dec_state_t state_reg;
    utf8v_pkg::dec_state_t state_next;
    utf8v_pkg::out_item_t  result_next;
    logic                  adv;
    logic                  step_fire;

    assign adv       = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || adv;
    assign step_fire = adv && in_valid_reg;

    utf8v_step u_step (
        .state_cur (state_reg),
        .item      (in_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
            // advance the decode state only when the item moves on
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (step_fire) begin
            out_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_reg.end_mark |=> (state_reg == '0))
        else $error("decode state not cleared after end of text");

    a_len_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.bytes_pending == 2'd0) |-> (state_reg.sequence_length == 3'd0))
        else $error("sequence length left open with nothing pending");

    a_len_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.bytes_pending != 2'd0) |->
            (state_reg.sequence_length > {1'b0, state_reg.bytes_pending}))
        else $error("pending count exceeds sequence length");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.error_seen && !(step_fire && in_reg.end_mark) |=> state_reg.error_seen)
        else $error("error flag dropped before end of text");

    a_err_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && state_reg.error_seen |=> m_data.text_invalid)
        else $error("known error not reported in verdict");
`endif

endmodule
